### hdl/ulj_pkg.sv
// Shared types and constants for the loss and jitter monitor.
package ulj_pkg;

   localparam int OP_W = 64;

   typedef enum logic [3:0] {
      S_IDLE, S_CHK, S_SEC, S_SQ, S_UPD, S_AVG, S_M1, S_M2,
      S_M3, S_VAR, S_SQRT, S_GP, S_TP, S_DONE
   } state_type;

   localparam logic [1:0] ST_COUNTED = 2'd0;
   localparam logic [1:0] ST_START   = 2'd1;
   localparam logic [1:0] ST_LATE    = 2'd2;

   localparam logic [1:0] CSR_DURATION = 2'd0;
   localparam logic [1:0] CSR_OVERHEAD = 2'd1;

   // ceil(2^68 / 1e6): x * US_RECIP >> 68 is floor(x / 1e6) for any 48-bit x
   localparam logic [OP_W-1:0] US_RECIP = 64'd295147905179353;

endpackage

### hdl/ulj_mul.sv
// Shift-add multiplier, 64 x 64 to 128 bits, one multiplier bit per cycle.
module ulj_mul
   import ulj_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [OP_W-1:0]   a,
   input  logic [OP_W-1:0]   b,
   output logic              done,
   output logic [2*OP_W-1:0] prod
);
   logic [OP_W-1:0] a_ff, hi_ff, lo_ff;
   logic [6:0]      cnt_ff;
   logic            busy_ff, done_ff;
   logic [OP_W:0]   sum;

   assign sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 7'd1;
            if (cnt_ff == 7'(OP_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff  <= a;
         hi_ff <= '0;
         lo_ff <= b;
      end else if (busy_ff) begin
         hi_ff <= sum[OP_W:1];
         lo_ff <= {sum[0], lo_ff[OP_W-1:1]};
      end
   end

   assign done = done_ff;
   assign prod = {hi_ff, lo_ff};
endmodule

### hdl/ulj_div.sv
// Restoring divider, 128-bit numerator by 64-bit divisor, one quotient bit per cycle.
module ulj_div
   import ulj_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [2*OP_W-1:0] num,
   input  logic [OP_W-1:0]   den,
   output logic              done,
   output logic [2*OP_W-1:0] quo
);
   logic [2*OP_W-1:0] q_ff;
   logic [OP_W-1:0]   rem_ff, d_ff;
   logic [6:0]        cnt_ff;
   logic              busy_ff, done_ff;
   logic [OP_W:0]     shifted, diff;
   logic              take;

   assign shifted = {rem_ff, q_ff[2*OP_W-1]};
   assign diff    = shifted - {1'b0, d_ff};
   assign take    = (shifted >= {1'b0, d_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 7'd1;
            if (cnt_ff == 7'(2*OP_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= num;
         rem_ff <= '0;
         d_ff   <= den;
      end else if (busy_ff) begin
         rem_ff <= take ? diff[OP_W-1:0] : shifted[OP_W-1:0];
         q_ff   <= {q_ff[2*OP_W-2:0], take};
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;
endmodule

### hdl/ulj_sqrt.sv
// Integer square root of a 64-bit value, one result bit per cycle.
module ulj_sqrt
   import ulj_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [OP_W-1:0]   x,
   output logic              done,
   output logic [OP_W/2-1:0] root
);
   logic [OP_W-1:0] x_ff, res_ff, bit_ff, trial;
   logic [4:0]      cnt_ff;
   logic            busy_ff, done_ff;

   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(OP_W/2 - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= x;
         res_ff <= '0;
         bit_ff <= {2'b01, {(OP_W-2){1'b0}}};
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_ff   <= x_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign done = done_ff;
   assign root = res_ff[OP_W/2-1:0];
endmodule

### hdl/udp_stream_loss_jitter_monitor.sv
// Top level: packet loss and interarrival jitter monitor with its sequencer.
//
//  channel  dir  handshake            payload
//  req_     in   valid / stall        arrival_us, seq_number, payload_len
//  rsp_     out  valid / stall        status .. throughput_kbps
//  csr_     in   valid / ready        index, data
//
// Per packet, a shared divider runs up to four times (mean, variance, goodput,
// throughput), a shared multiplier up to five times (second index by reciprocal,
// jitter square, three variance products), and the square root at most once.
// Reset is synchronous; no clearing pass is needed. csr_ready is always high.
// A new packet is taken once the previous result moves to the output register,
// even while that result is still stalled.
module udp_stream_loss_jitter_monitor
   import ulj_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [47:0] req_arrival_us,
   input  logic [31:0] req_seq_number,
   input  logic [15:0] req_payload_len,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [23:0] rsp_second_index,
   output logic signed [31:0] rsp_lost_count,
   output logic [47:0] rsp_payload_total,
   output logic [47:0] rsp_transmitted_total,
   output logic [31:0] rsp_jitter_avg_us,
   output logic [31:0] rsp_jitter_stddev_us,
   output logic [31:0] rsp_jitter_count,
   output logic [31:0] rsp_goodput_kbps,
   output logic [31:0] rsp_throughput_kbps,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [39:0] csr_data
);
   state_type state_ff, state_in;
   logic      launched_ff, launched_in;

   logic [39:0] duration_ff;
   logic [7:0]  overhead_ff;

   logic        started_ff, ended_ff;
   logic [47:0] start_time_ff, prev_time_ff, prev_gap_ff;
   logic [31:0] expected_seq_ff, lost_ff;
   logic [47:0] payload_ff, transmitted_ff, jsum_ff;
   logic [63:0] jsq_ff;
   logic [31:0] jcnt_ff;

   logic [47:0] arr_ff;
   logic [31:0] seq_ff;
   logic [15:0] len_ff;

   logic [1:0]  status_ff;
   logic [23:0] sec_ff;
   logic [31:0] avg_ff, std_ff, good_ff, thr_ff;
   logic [95:0] nsq_ff, var_num_ff;
   logic [63:0] var_den_ff;
   logic        rsp_valid_ff;

   logic               mul_start, div_start, sqrt_start;
   logic               mul_done, div_done, sqrt_done;
   logic [OP_W-1:0]    mul_a, mul_b, div_den;
   logic [2*OP_W-1:0]  mul_prod, div_num, div_quo;
   logic [OP_W/2-1:0]  sqrt_root;

   logic [47:0] elapsed, gap, jit;
   logic [34:0] rate_den;
   logic [31:0] seq_diff;
   logic [32:0] lost_sum;
   logic [48:0] pay_sum, tx_sum, jsum_sum;
   logic [64:0] jsq_sum;
   logic [63:0] jsq_add;
   logic [31:0] q32_sat;
   logic        finish;

   assign elapsed  = arr_ff - start_time_ff;
   assign gap      = arr_ff - prev_time_ff;
   assign jit      = (gap >= prev_gap_ff) ? gap - prev_gap_ff : prev_gap_ff - gap;
   assign rate_den = (35'(sec_ff) + 35'd1) * 35'd1000;
   assign seq_diff = seq_ff - expected_seq_ff;
   assign lost_sum = {lost_ff[31], lost_ff} + {seq_diff[31], seq_diff};
   assign pay_sum  = {1'b0, payload_ff} + 49'(len_ff);
   assign tx_sum   = {1'b0, transmitted_ff} + 49'(len_ff) + 49'(overhead_ff);
   assign jsum_sum = {1'b0, jsum_ff} + {1'b0, jit};
   assign jsq_add  = (jit[47:32] != '0) ? '1 : mul_prod[63:0];
   assign jsq_sum  = {1'b0, jsq_ff} + {1'b0, jsq_add};
   assign q32_sat  = (div_quo[127:32] != '0) ? '1 : div_quo[31:0];
   assign finish   = !(rsp_valid_ff && rsp_stall);

   ulj_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .prod(mul_prod)
   );

   ulj_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .done(div_done), .quo(div_quo)
   );

   ulj_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .x(div_quo[63:0]),
      .done(sqrt_done), .root(sqrt_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         launched_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         launched_ff <= launched_in;
      end
   end

   // sequencer: each arithmetic state launches its unit at most once (S_AVG and S_M1 may skip it), then waits for done
   always_comb begin
      state_in    = state_ff;
      launched_in = launched_ff;
      mul_start   = 1'b0;
      div_start   = 1'b0;
      sqrt_start  = 1'b0;
      mul_a       = '0;
      mul_b       = '0;
      div_num     = '0;
      div_den     = 64'd1;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_CHK;
         S_CHK:  state_in = started_ff ? S_SEC : S_AVG;
         S_SEC: begin
            mul_a = 64'(elapsed);
            mul_b = US_RECIP;
            if (!launched_ff) begin
               mul_start = 1'b1;
               launched_in = 1'b1;
            end else if (mul_done) begin
               launched_in = 1'b0;
               if (ended_ff || elapsed >= 48'(duration_ff)) state_in = S_AVG;
               else if (prev_gap_ff != '0) state_in = S_SQ;
               else state_in = S_UPD;
            end
         end
         S_SQ: begin
            mul_a = 64'(jit);
            mul_b = 64'(jit);
            if (!launched_ff) begin
               mul_start = 1'b1;
               launched_in = 1'b1;
            end else if (mul_done) begin
               launched_in = 1'b0;
               state_in = S_UPD;
            end
         end
         S_UPD: state_in = S_AVG;
         S_AVG: begin
            div_num = 128'(jsum_ff);
            div_den = 64'(jcnt_ff);
            if (!launched_ff) begin
               if (jcnt_ff == '0) state_in = S_M1;
               else begin
                  div_start = 1'b1;
                  launched_in = 1'b1;
               end
            end else if (div_done) begin
               launched_in = 1'b0;
               state_in = S_M1;
            end
         end
         S_M1: begin
            mul_a = 64'(jcnt_ff);
            mul_b = jsq_ff;
            if (!launched_ff) begin
               if (jcnt_ff < 32'd2) state_in = S_GP;
               else begin
                  mul_start = 1'b1;
                  launched_in = 1'b1;
               end
            end else if (mul_done) begin
               launched_in = 1'b0;
               state_in = S_M2;
            end
         end
         S_M2: begin
            mul_a = 64'(jsum_ff);
            mul_b = 64'(jsum_ff);
            if (!launched_ff) begin
               mul_start = 1'b1;
               launched_in = 1'b1;
            end else if (mul_done) begin
               launched_in = 1'b0;
               state_in = (nsq_ff < mul_prod[95:0]) ? S_GP : S_M3;
            end
         end
         S_M3: begin
            mul_a = 64'(jcnt_ff);
            mul_b = 64'(jcnt_ff - 32'd1);
            if (!launched_ff) begin
               mul_start = 1'b1;
               launched_in = 1'b1;
            end else if (mul_done) begin
               launched_in = 1'b0;
               state_in = S_VAR;
            end
         end
         S_VAR: begin
            div_num = 128'(var_num_ff);
            div_den = var_den_ff;
            if (!launched_ff) begin
               div_start = 1'b1;
               launched_in = 1'b1;
            end else if (div_done) begin
               launched_in = 1'b0;
               state_in = (div_quo[127:64] != '0) ? S_GP : S_SQRT;
            end
         end
         S_SQRT: begin
            if (!launched_ff) begin
               sqrt_start = 1'b1;
               launched_in = 1'b1;
            end else if (sqrt_done) begin
               launched_in = 1'b0;
               state_in = S_GP;
            end
         end
         S_GP, S_TP: begin
            div_num = (state_ff == S_GP) ? 128'({payload_ff, 3'b000})
                                         : 128'({transmitted_ff, 3'b000});
            div_den = 64'(rate_den);
            if (!launched_ff) begin
               div_start = 1'b1;
               launched_in = 1'b1;
            end else if (div_done) begin
               launched_in = 1'b0;
               state_in = (state_ff == S_GP) ? S_TP : S_DONE;
            end
         end
         S_DONE: if (finish) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // monitor state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff     <= 40'd10000000;
         overhead_ff     <= 8'd28;
         started_ff      <= 1'b0;
         ended_ff        <= 1'b0;
         start_time_ff   <= '0;
         prev_time_ff    <= '0;
         prev_gap_ff     <= '0;
         expected_seq_ff <= '0;
         lost_ff         <= '0;
         payload_ff      <= '0;
         transmitted_ff  <= '0;
         jsum_ff         <= '0;
         jsq_ff          <= '0;
         jcnt_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_DURATION) duration_ff <= csr_data;
            else if (csr_index == CSR_OVERHEAD) overhead_ff <= csr_data[7:0];
         end
         if (state_ff == S_CHK && !started_ff) begin
            started_ff    <= 1'b1;
            start_time_ff <= arr_ff;
            prev_time_ff  <= arr_ff;
         end
         if (state_ff == S_SEC && mul_done &&
             (ended_ff || elapsed >= 48'(duration_ff))) begin
            ended_ff <= 1'b1;
         end
         if (state_ff == S_SQ && mul_done) begin
            jsum_ff <= jsum_sum[48] ? '1 : jsum_sum[47:0];
            jsq_ff  <= jsq_sum[64] ? '1 : jsq_sum[63:0];
            if (jcnt_ff != '1) jcnt_ff <= jcnt_ff + 32'd1;
         end
         if (state_ff == S_UPD) begin
            prev_gap_ff  <= gap;
            prev_time_ff <= arr_ff;
            if (lost_sum[32] != lost_sum[31])
               lost_ff <= lost_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else
               lost_ff <= lost_sum[31:0];
            expected_seq_ff <= seq_ff + 32'd1;
            payload_ff      <= pay_sum[48] ? '1 : pay_sum[47:0];
            transmitted_ff  <= tx_sum[48] ? '1 : tx_sum[47:0];
         end
         if (state_ff == S_DONE && finish) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // per-packet working values
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         arr_ff <= req_arrival_us;
         seq_ff <= req_seq_number;
         len_ff <= req_payload_len;
      end
      if (state_ff == S_CHK) begin
         status_ff <= ST_START;
         sec_ff    <= '0;
         avg_ff    <= '0;
         std_ff    <= '0;
      end
      if (state_ff == S_SEC && mul_done) begin
         sec_ff    <= (mul_prod[127:92] != '0) ? '1 : mul_prod[91:68];
         status_ff <= (ended_ff || elapsed >= 48'(duration_ff)) ? ST_LATE : ST_COUNTED;
      end
      if (state_ff == S_AVG && div_done) avg_ff <= q32_sat;
      if (state_ff == S_M1 && mul_done) nsq_ff <= mul_prod[95:0];
      if (state_ff == S_M2 && mul_done) var_num_ff <= nsq_ff - mul_prod[95:0];
      if (state_ff == S_M3 && mul_done) var_den_ff <= mul_prod[63:0];
      if (state_ff == S_VAR && div_done && div_quo[127:64] != '0) std_ff <= '1;
      if (state_ff == S_SQRT && sqrt_done) std_ff <= sqrt_root;
      if (state_ff == S_GP && div_done) good_ff <= q32_sat;
      if (state_ff == S_TP && div_done) thr_ff <= q32_sat;
   end

   // output register
   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && finish) begin
         rsp_status            <= status_ff;
         rsp_second_index      <= sec_ff;
         rsp_lost_count        <= lost_ff;
         rsp_payload_total     <= payload_ff;
         rsp_transmitted_total <= transmitted_ff;
         rsp_jitter_avg_us     <= avg_ff;
         rsp_jitter_stddev_us  <= std_ff;
         rsp_jitter_count      <= jcnt_ff;
         rsp_goodput_kbps      <= good_ff;
         rsp_throughput_kbps   <= thr_ff;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign csr_ready = 1'b1;

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({mul_start, div_start, sqrt_start}))
      else $error("two arithmetic units launched together");

   a_end_after_start: assert property (@(posedge clock) disable iff (reset)
      ended_ff |-> started_ff)
      else $error("measurement ended before it started");

   a_counted_needs_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_COUNTED) |-> started_ff)
      else $error("counted packet reported before start");

   a_launch_clears: assert property (@(posedge clock) disable iff (reset)
      (mul_done || div_done || sqrt_done) |-> launched_ff)
      else $error("unit finished without a launch");
endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the packet loss and interarrival jitter monitor.
`timescale 1ns / 100ps

module testbench;
   import ulj_pkg::*;

   localparam int SETTLE_CYCLES = 1200;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES = 3000;
   localparam logic [63:0] M32 = 64'hFFFF_FFFF;
   localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;

   typedef enum logic [1:0] {OP_PACKET, OP_CSR, OP_DRAIN} op_kind_type;

   typedef struct {
      op_kind_type kind;
      logic [47:0] arrival;
      logic [31:0] seq;
      logic [15:0] len;
      logic [1:0]  index;
      logic [39:0] data;
   } op_type;

   typedef struct {
      logic [1:0]  status;
      logic [23:0] sec;
      logic [31:0] lost;
      logic [47:0] payload;
      logic [47:0] transmitted;
      logic [31:0] avg;
      logic [31:0] stddev;
      logic [31:0] count;
      logic [31:0] goodput;
      logic [31:0] throughput;
   } stats_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [47:0] req_arrival_us = '0;
   logic [31:0] req_seq_number = '0;
   logic [15:0] req_payload_len = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [23:0] rsp_second_index;
   logic signed [31:0] rsp_lost_count;
   logic [47:0] rsp_payload_total, rsp_transmitted_total;
   logic [31:0] rsp_jitter_avg_us, rsp_jitter_stddev_us, rsp_jitter_count;
   logic [31:0] rsp_goodput_kbps, rsp_throughput_kbps;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [39:0] csr_data = '0;

   op_type    pending_ops[$];
   stats_type expected_stats[$];
   int errors = 0;
   int results_seen = 0;
   int packets_sent = 0;
   int idle_cycles = 0;
   logic hold_active = 1'b0;

   // model state
   logic [39:0] m_duration;
   logic [7:0]  m_overhead;
   logic        m_started, m_ended;
   logic [47:0] m_start, m_prev_time, m_prev_gap;
   logic [31:0] m_exp_seq, m_lost;
   logic [47:0] m_payload, m_transmitted, m_jsum;
   logic [63:0] m_jsq;
   logic [31:0] m_samples;

   always #1 clock = ~clock;

   udp_stream_loss_jitter_monitor i_dut (.*);

   function automatic logic [63:0] isqrt(logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [31:0] rate_kbps(logic [47:0] bytes, logic [23:0] sec);
      logic [63:0] q;
      q = ({16'b0, bytes} << 3) / ((64'(sec) + 64'd1) * 64'd1000);
      return (q > M32) ? M32 : q[31:0];
   endfunction

   function automatic logic [31:0] sample_sigma();
      logic [127:0] a, b, q;
      logic [63:0] n;
      n = 64'(m_samples);
      if (n < 64'd2) return '0;
      a = 128'(n) * 128'(m_jsq);
      b = 128'(m_jsum) * 128'(m_jsum);
      if (a < b) return '0;
      q = (a - b) / 128'(n * (n - 64'd1));
      if (q[127:64] != 0) return M32[31:0];
      return 32'(isqrt(q[63:0]));
   endfunction

   task automatic reset_model();
      m_duration = 40'd10000000;
      m_overhead = 8'd28;
      m_started = 1'b0;
      m_ended = 1'b0;
      m_start = '0;
      m_prev_time = '0;
      m_prev_gap = '0;
      m_exp_seq = '0;
      m_lost = '0;
      m_payload = '0;
      m_transmitted = '0;
      m_jsum = '0;
      m_jsq = '0;
      m_samples = '0;
   endtask

   task automatic predict_stats(logic [47:0] arrival, logic [31:0] seq, logic [15:0] len);
      stats_type s;
      logic [47:0] elapsed, gap, j;
      logic [63:0] sq, avg, secw;
      logic [48:0] sum48;
      logic [64:0] sum64;
      logic [31:0] diff;
      logic signed [63:0] lost;
      secw = '0;
      if (!m_started) begin
         m_started = 1'b1;
         m_start = arrival;
         m_prev_time = arrival;
         s.status = ST_START;
      end else begin
         elapsed = arrival - m_start;
         secw = 64'(elapsed) / 64'd1000000;
         if (secw > 64'hFF_FFFF) secw = 64'hFF_FFFF;
         if (m_ended || 64'(elapsed) >= 64'(m_duration)) begin
            m_ended = 1'b1;
            s.status = ST_LATE;
         end else begin
            s.status = ST_COUNTED;
            gap = arrival - m_prev_time;
            if (m_prev_gap > 0) begin
               j = (gap >= m_prev_gap) ? gap - m_prev_gap : m_prev_gap - gap;
               sq = (64'(j) > M32) ? '1 : 64'(j) * 64'(j);
               sum48 = 49'(m_jsum) + 49'(j);
               m_jsum = sum48[48] ? M48 : sum48[47:0];
               sum64 = 65'(m_jsq) + 65'(sq);
               m_jsq = sum64[64] ? '1 : sum64[63:0];
               if (m_samples != '1) m_samples++;
            end
            m_prev_gap = gap;
            m_prev_time = arrival;
            diff = seq - m_exp_seq;
            lost = 64'($signed(m_lost)) + 64'($signed(diff));
            if (lost > 64'sd2147483647) lost = 64'sd2147483647;
            if (lost < -64'sd2147483648) lost = -64'sd2147483648;
            m_lost = lost[31:0];
            m_exp_seq = seq + 32'd1;
            sum48 = 49'(m_payload) + 49'(len);
            m_payload = sum48[48] ? M48 : sum48[47:0];
            sum48 = 49'(m_transmitted) + 49'(len) + 49'(m_overhead);
            m_transmitted = sum48[48] ? M48 : sum48[47:0];
         end
      end
      avg = '0;
      if (m_samples != 0) begin
         avg = 64'(m_jsum) / 64'(m_samples);
         if (avg > M32) avg = M32;
      end
      s.sec = secw[23:0];
      s.lost = m_lost;
      s.payload = m_payload;
      s.transmitted = m_transmitted;
      s.avg = avg[31:0];
      s.stddev = sample_sigma();
      s.count = m_samples;
      s.goodput = rate_kbps(m_payload, s.sec);
      s.throughput = rate_kbps(m_transmitted, s.sec);
      expected_stats.push_back(s);
   endtask

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
   endtask

   // mostly short random waits, with runs of back-to-back transfers
   function automatic int draw_wait(int n);
      if ((n % 80) < 20) return 0;
      return $urandom_range(0, 9);
   endfunction

   // driver
   int send_wait = 0;
   int settle = 0;
   always @(posedge clock) begin
      logic offering;
      logic csr_next;
      op_type op;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         offering = req_valid;
         csr_next = csr_valid;
         if (req_valid && !req_stall) begin
            predict_stats(req_arrival_us, req_seq_number, req_payload_len);
            packets_sent++;
            offering = 1'b0;
            send_wait = draw_wait(packets_sent);
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_DURATION) m_duration = csr_data;
            else if (csr_index == CSR_OVERHEAD) m_overhead = csr_data[7:0];
            csr_next = 1'b0;
         end
         if (!offering && !csr_next) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (pending_ops.size() > 0) begin
               op = pending_ops[0];
               case (op.kind)
                  OP_PACKET: begin
                     req_arrival_us <= op.arrival;
                     req_seq_number <= op.seq;
                     req_payload_len <= op.len;
                     offering = 1'b1;
                     void'(pending_ops.pop_front());
                  end
                  OP_DRAIN: begin
                     if (expected_stats.size() == 0) void'(pending_ops.pop_front());
                  end
                  default: begin
                     if (expected_stats.size() != 0) begin
                        settle = 0;
                     end else if (settle < SETTLE_CYCLES) begin
                        settle++;
                     end else begin
                        settle = 0;
                        csr_index <= op.index;
                        csr_data <= op.data;
                        csr_next = 1'b1;
                        void'(pending_ops.pop_front());
                     end
                  end
               endcase
            end
         end
         req_valid <= offering;
         csr_valid <= csr_next;
      end
   end

   // monitor
   int recv_wait = 0;
   always @(posedge clock) begin
      stats_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            recv_wait = draw_wait(results_seen + 37);
            if (expected_stats.size() == 0) begin
               errors++;
               $display("%0t: result transfer with nothing expected, actual status %0h",
                        $time, rsp_status);
            end else begin
               e = expected_stats.pop_front();
               check_field("status", e.status, rsp_status);
               check_field("second_index", e.sec, rsp_second_index);
               check_field("lost_count", e.lost, $unsigned(rsp_lost_count));
               check_field("payload_total", e.payload, rsp_payload_total);
               check_field("transmitted_total", e.transmitted, rsp_transmitted_total);
               check_field("jitter_avg_us", e.avg, rsp_jitter_avg_us);
               check_field("jitter_stddev_us", e.stddev, rsp_jitter_stddev_us);
               check_field("jitter_count", e.count, rsp_jitter_count);
               check_field("goodput_kbps", e.goodput, rsp_goodput_kbps);
               check_field("throughput_kbps", e.throughput, rsp_throughput_kbps);
            end
         end else if (recv_wait > 0) begin
            recv_wait--;
         end
         rsp_stall <= hold_active || (recv_wait > 0);
      end
   end

   // one long receiver hold-off while the driver keeps offering packets
   int hold_count = 0;
   logic hold_done = 1'b0;
   always @(posedge clock) begin
      if (!reset && !hold_done) begin
         if (hold_active) begin
            hold_count++;
            if (hold_count >= HOLD_CYCLES) begin
               hold_active <= 1'b0;
               hold_done <= 1'b1;
            end
         end else if (results_seen >= 150) begin
            hold_active <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // stimulus generation
   logic [47:0] gen_time;
   logic [31:0] gen_seq;
   logic [47:0] gen_gap;

   task automatic add_packet(logic [47:0] gap, logic [31:0] seq, logic [15:0] len);
      op_type op;
      gen_time = gen_time + gap;
      gen_seq = seq;
      op.kind = OP_PACKET;
      op.arrival = gen_time;
      op.seq = seq;
      op.len = len;
      op.index = '0;
      op.data = '0;
      pending_ops.push_back(op);
   endtask

   task automatic add_csr(logic [1:0] index, logic [39:0] data);
      op_type op;
      op.kind = OP_CSR;
      op.arrival = '0;
      op.seq = '0;
      op.len = '0;
      op.index = index;
      op.data = data;
      pending_ops.push_back(op);
   endtask

   task automatic add_drain();
      op_type op;
      op.kind = OP_DRAIN;
      op.arrival = '0;
      op.seq = '0;
      op.len = '0;
      op.index = '0;
      op.data = '0;
      pending_ops.push_back(op);
   endtask

   task automatic add_random_packets(int n);
      logic [47:0] gap;
      logic [31:0] seq;
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) gap = '0;
         else if (pick < 30) gap = gen_gap;
         else if (pick < 95) gap = 48'($urandom_range(1, 20000));
         else gap = 48'($urandom_range(1000000, 3000000));
         gen_gap = gap;
         pick = $urandom_range(0, 99);
         if (pick < 80) seq = gen_seq + 32'd1;
         else if (pick < 90) seq = gen_seq + 32'($urandom_range(2, 6));
         else if (pick < 95) seq = gen_seq - 32'($urandom_range(0, 5));
         else seq = $urandom;
         add_packet(gap, seq, 16'($urandom_range(0, 65535)));
      end
   endtask

   initial begin
      reset_model();
      // start close to the timestamp wrap so the arrival timestamps roll over
      gen_time = 48'hFFFF_FFFF_F000 - 48'd20;
      gen_gap = '0;
      add_packet(48'd20, 32'hDEAD_BEEF, 16'hFFFF);
      add_packet(48'd100, 32'd0, 16'd0);
      add_packet(48'd0, 32'd1, 16'hFFFF);
      add_packet(48'd0, 32'd2, 16'd1);
      add_packet(48'd500, 32'd6, 16'd1500);
      add_packet(48'd500, 32'd4, 16'd64);
      add_packet(48'd700, 32'd5, 16'd0);
      add_packet(48'd700, 32'hFFFF_FFFF, 16'hFFFF);
      add_packet(48'd1, 32'd0, 16'hAAAA);
      add_packet(48'd2500000, 32'h8000_0000, 16'h5555);
      add_packet(48'd3, 32'h0000_0001, 16'd1);
      add_packet(48'hFFFF, 32'h7FFF_FFFF, 16'h8000);
      add_packet(48'd12, 32'h8000_0000, 16'h7FFF);
      add_packet(48'd3000000, 32'h8000_0001, 16'd9000);
      add_csr(CSR_OVERHEAD, 40'd0);
      add_csr(CSR_DURATION, 40'hFF_FFFF_FFFF);
      add_random_packets(300);
      add_drain();
      add_random_packets(20);
      add_csr(CSR_OVERHEAD, 40'hFF_FFFF_FFFF);
      add_random_packets(300);
      add_csr(CSR_OVERHEAD, {$urandom, 8'($urandom)});
      add_csr(CSR_DURATION, 40'd1);
      for (int i = 0; i < 12; i++) begin
         if (i % 3 == 0) add_packet({$urandom, 16'($urandom)}, $urandom, 16'($urandom));
         else add_random_packets(1);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (pending_ops.size() == 0 && !req_valid && !csr_valid);
      wait (expected_stats.size() == 0);
      repeat (2000) @(posedge clock);
      if (expected_stats.size() != 0) begin
         errors++;
         $display("%0t: %0d results still expected, actual none", $time, expected_stats.size());
      end
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
